/* hw/rtl/mamt_pkg.sv */
package mamt_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 20;
  localparam int TIME_W          = 32;
  localparam int COUNT_W         = 32;
  localparam int CFG_W           = 7;

endpackage

/* hw/rtl/mamt_if.sv */
interface mamt_in_if #(
  parameter int SAMPLE_BITS = mamt_pkg::SAMPLE_BITS_DEF
);
  import mamt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   series_start;
  logic [TIME_W-1:0]      sample_time;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output series_start, output sample_time,
                  output sample_value, input ready);
  modport sink   (input valid, input series_start, input sample_time,
                  input sample_value, output ready);
endinterface

interface mamt_out_if #(
  parameter int SAMPLE_BITS = mamt_pkg::SAMPLE_BITS_DEF
);
  import mamt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TIME_W-1:0]      time_out;
  logic [SAMPLE_BITS-1:0] filtered_value;
  logic [SAMPLE_BITS-1:0] series_min;
  logic [SAMPLE_BITS-1:0] series_max;
  logic [SAMPLE_BITS-1:0] series_mean;
  logic [COUNT_W-1:0]     sample_count;

  modport source (output valid, output time_out, output filtered_value,
                  output series_min, output series_max, output series_mean,
                  output sample_count, input ready);
  modport sink   (input valid, input time_out, input filtered_value,
                  input series_min, input series_max, input series_mean,
                  input sample_count, output ready);
endinterface

interface mamt_cfg_if;
  import mamt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

/* hw/rtl/moving_average_min_max_tracker.sv */
// Channel   Port     Dir  Transaction
// -------   ------   ---  ----------------------------------------------------
// input     in_ch    in   series_start, sample_time, sample_value
// result    out_ch   out  time_out, filtered_value, series_min/max/mean, count
// config    cfg_ch   in   window_length (always ready)
//
// Steps per item: on a series start, a window fill sweep, then bit-serial
// division of the series sum; otherwise one memory read per window entry,
// then the same division. The 52-bit series-sum divider sets the tail of
// every item.
// Reset (rst_n low, synchronous) clears control and statistics; the window
// memory is not cleared and is filled on each series start.
// A finished result waits in the output register while the next transaction
// is taken; a stall on out_ch holds the engine only at its final step.
module moving_average_min_max_tracker #(
  parameter int MAX_WINDOW  = mamt_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mamt_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mamt_in_if.sink    in_ch,
  mamt_out_if.source out_ch,
  mamt_cfg_if.sink   cfg_ch
);
  import mamt_pkg::*;

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int WSUM_W = SAMPLE_BITS + LEN_W;
  localparam int SSUM_W = SAMPLE_BITS + COUNT_W;
  localparam int DCNT_W = $clog2(SSUM_W + 1);
  localparam int WREM_W = LEN_W + 1;
  localparam int SREM_W = COUNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRIME, ST_WRITE, ST_SUM, ST_SETUP, ST_DIV, ST_FIN
  } state_t;

  state_t                 state_r;
  logic [CFG_W-1:0]       cfg_len_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [TIME_W-1:0]      time_r;
  logic [LEN_W-1:0]       len_r;
  logic [IDX_W-1:0]       pos_r;
  logic [IDX_W-1:0]       wp_r;
  logic [SSUM_W-1:0]      ssum_r;
  logic [COUNT_W-1:0]     count_r;
  logic [SAMPLE_BITS-1:0] low_r;
  logic [SAMPLE_BITS-1:0] high_r;
  logic [LEN_W-1:0]       idx_r;
  logic                   rd_vld_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [WSUM_W-1:0]      wacc_r;
  logic [WSUM_W-1:0]      wq_r;
  logic [WREM_W-1:0]      wrem_r;
  logic                   wneg_r;
  logic [SSUM_W-1:0]      sq_r;
  logic [SREM_W-1:0]      srem_r;
  logic                   sneg_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic                   out_valid_r;
  logic [TIME_W-1:0]      out_time_r;
  logic [SAMPLE_BITS-1:0] out_filt_r;
  logic [SAMPLE_BITS-1:0] out_min_r;
  logic [SAMPLE_BITS-1:0] out_max_r;
  logic [SAMPLE_BITS-1:0] out_mean_r;
  logic [COUNT_W-1:0]     out_count_r;

  logic [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW];

  logic                   in_fire;
  logic [LEN_W-1:0]       eff_len;
  logic                   start_w;
  logic [IDX_W-1:0]       base_pos;
  logic [IDX_W-1:0]       pos_w;
  logic [LEN_W-1:0]       pos_inc;
  logic [IDX_W-1:0]       wp_nxt;
  logic [SSUM_W-1:0]      smp_sx;
  logic [SSUM_W-1:0]      ssum_nxt;
  logic [COUNT_W-1:0]     count_nxt;
  logic [SAMPLE_BITS-1:0] low_nxt;
  logic [SAMPLE_BITS-1:0] high_nxt;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic                   rd_en;
  logic [WSUM_W-1:0]      rd_sx;
  logic [WSUM_W-1:0]      prime_sx;
  logic [WSUM_W-1:0]      wacc_mag;
  logic [SSUM_W-1:0]      ssum_mag;
  logic [WREM_W-1:0]      wrem_sh;
  logic                   wge;
  logic [WREM_W-1:0]      wrem_new;
  logic [SREM_W-1:0]      srem_sh;
  logic                   sge;
  logic [SREM_W-1:0]      srem_new;
  logic [WSUM_W-1:0]      wq_fin;
  logic [SSUM_W-1:0]      sq_fin;
  logic                   out_free;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (cfg_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(cfg_len_r) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(cfg_len_r);
    end
  end

  assign start_w  = in_ch.series_start || (count_r == '0);
  assign base_pos = start_w ? '0 : wp_r;
  assign pos_w    = (LEN_W'(base_pos) >= eff_len) ? '0 : base_pos;
  assign pos_inc  = LEN_W'(pos_w) + LEN_W'(1);
  assign wp_nxt   = (pos_inc >= eff_len) ? '0 : pos_inc[IDX_W-1:0];

  assign smp_sx = {{COUNT_W{in_ch.sample_value[SAMPLE_BITS-1]}}, in_ch.sample_value};

  always_comb begin
    if (start_w) begin
      ssum_nxt  = smp_sx;
      count_nxt = COUNT_W'(1);
      low_nxt   = in_ch.sample_value;
      high_nxt  = in_ch.sample_value;
    end else begin
      if (count_r == '1) begin
        ssum_nxt  = ssum_r;
        count_nxt = count_r;
      end else begin
        ssum_nxt  = ssum_r + smp_sx;
        count_nxt = count_r + COUNT_W'(1);
      end
      low_nxt  = ($signed(in_ch.sample_value) < $signed(low_r))  ? in_ch.sample_value : low_r;
      high_nxt = ($signed(in_ch.sample_value) > $signed(high_r)) ? in_ch.sample_value : high_r;
    end
  end

  assign mem_we    = (state_r == ST_PRIME) || (state_r == ST_WRITE);
  assign mem_waddr = (state_r == ST_PRIME) ? idx_r[IDX_W-1:0] : pos_r;
  assign rd_en     = (state_r == ST_SUM) && (idx_r < len_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= win_mem[idx_r[IDX_W-1:0]];
  end

  assign rd_sx    = {{LEN_W{rd_data_r[SAMPLE_BITS-1]}}, rd_data_r};
  assign prime_sx = {{LEN_W{smp_r[SAMPLE_BITS-1]}}, smp_r};
  assign wacc_mag = wacc_r[WSUM_W-1] ? (~wacc_r + WSUM_W'(1)) : wacc_r;
  assign ssum_mag = ssum_r[SSUM_W-1] ? (~ssum_r + SSUM_W'(1)) : ssum_r;

  assign wrem_sh  = {wrem_r[WREM_W-2:0], wq_r[WSUM_W-1]};
  assign wge      = (wrem_sh >= WREM_W'(len_r));
  assign wrem_new = wge ? (wrem_sh - WREM_W'(len_r)) : wrem_sh;
  assign srem_sh  = {srem_r[SREM_W-2:0], sq_r[SSUM_W-1]};
  assign sge      = (srem_sh >= SREM_W'(count_r));
  assign srem_new = sge ? (srem_sh - SREM_W'(count_r)) : srem_sh;

  assign wq_fin   = wneg_r ? (~wq_r + WSUM_W'(1)) : wq_r;
  assign sq_fin   = sneg_r ? (~sq_r + SSUM_W'(1)) : sq_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_len_r   <= CFG_W'(1);
      wp_r        <= '0;
      ssum_r      <= '0;
      count_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cfg_len_r <= cfg_ch.window_length;
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= rd_en;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            smp_r   <= in_ch.sample_value;
            time_r  <= in_ch.sample_time;
            len_r   <= eff_len;
            pos_r   <= pos_w;
            wp_r    <= wp_nxt;
            ssum_r  <= ssum_nxt;
            count_r <= count_nxt;
            low_r   <= low_nxt;
            high_r  <= high_nxt;
            idx_r   <= '0;
            wacc_r  <= '0;
            state_r <= start_w ? ST_PRIME : ST_WRITE;
          end
        end
        ST_PRIME: begin
          if (idx_r < len_r) begin
            wacc_r <= wacc_r + prime_sx;
          end
          idx_r <= idx_r + LEN_W'(1);
          if (idx_r == LEN_W'(MAX_WINDOW - 1)) begin
            state_r <= ST_SETUP;
          end
        end
        ST_WRITE: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (rd_en) begin
            idx_r <= idx_r + LEN_W'(1);
          end
          if (rd_vld_r) begin
            wacc_r <= wacc_r + rd_sx;
          end else if (idx_r == len_r) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          wq_r    <= wacc_mag;
          wneg_r  <= wacc_r[WSUM_W-1];
          wrem_r  <= '0;
          sq_r    <= ssum_mag;
          sneg_r  <= ssum_r[SSUM_W-1];
          srem_r  <= '0;
          dcnt_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (dcnt_r < DCNT_W'(WSUM_W)) begin
            wrem_r <= wrem_new;
            wq_r   <= {wq_r[WSUM_W-2:0], wge};
          end
          srem_r <= srem_new;
          sq_r   <= {sq_r[SSUM_W-2:0], sge};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(SSUM_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_time_r  <= time_r;
            out_filt_r  <= wq_fin[SAMPLE_BITS-1:0];
            out_min_r   <= low_r;
            out_max_r   <= high_r;
            out_mean_r  <= sq_fin[SAMPLE_BITS-1:0];
            out_count_r <= count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.time_out       = out_time_r;
  assign out_ch.filtered_value = out_filt_r;
  assign out_ch.series_min     = out_min_r;
  assign out_ch.series_max     = out_max_r;
  assign out_ch.series_mean    = out_mean_r;
  assign out_ch.sample_count   = out_count_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("engine idle right after a transaction");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (count_r != '0))
    else $error("sample count zero after a transaction");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> ($signed(low_r) <= $signed(high_r)))
    else $error("series minimum above maximum");

  a_sum_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (idx_r <= len_r))
    else $error("window read index past window length");
`endif

endmodule

/* verif/moving_average_min_max_tracker_checker.sv */
`timescale 1ns / 1ps
module moving_average_min_max_tracker_checker (
  input  logic clk,
  input  logic rst_n,
  mamt_in_if   in_mon,
  mamt_out_if  out_mon,
  mamt_cfg_if  cfg_mon,
  output int   fail_count,
  output int   results_seen
);
  import mamt_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int DEPTH = MAX_WINDOW_DEF;
  localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [SW-1:0]      filtered;
    logic [SW-1:0]      low;
    logic [SW-1:0]      high;
    logic [SW-1:0]      mean;
    logic [COUNT_W-1:0] count;
  } filter_result_t;

  logic signed [SW-1:0] window_mem [DEPTH];
  int unsigned          wr_pos;
  longint               run_sum;
  longint unsigned      run_count;
  logic signed [SW-1:0] lo_mark;
  logic signed [SW-1:0] hi_mark;
  logic [CFG_W-1:0]     win_len_reg;
  filter_result_t       pending_results [$];
  int                   mismatches = 0;
  int                   checked = 0;

  function automatic filter_result_t advance_filter(bit st, logic [TIME_W-1:0] stamp,
                                                    logic [SW-1:0] raw);
    logic signed [SW-1:0] smp;
    int unsigned          len;
    longint               acc;
    longint               quot;
    longint               avg;
    filter_result_t       r;
    smp = raw;
    if (win_len_reg == 0) begin
      len = 1;
    end else if (win_len_reg > DEPTH) begin
      len = DEPTH;
    end else begin
      len = 32'(win_len_reg);
    end
    if (st || run_count == 0) begin
      for (int i = 0; i < DEPTH; i++) window_mem[i] = smp;
      wr_pos = 0;
      run_sum = 0;
      run_count = 0;
      lo_mark = smp;
      hi_mark = smp;
    end
    if (wr_pos >= len) wr_pos = 0;
    window_mem[wr_pos] = smp;
    wr_pos++;
    if (wr_pos >= len) wr_pos = 0;
    acc = 0;
    for (int i = 0; i < len; i++) acc += window_mem[i];
    if (run_count < COUNT_CAP) begin
      run_sum += smp;
      run_count++;
    end
    if (smp < lo_mark) lo_mark = smp;
    if (smp > hi_mark) hi_mark = smp;
    quot = acc / longint'(len);
    avg = run_sum / longint'(run_count);
    r.stamp = stamp;
    r.filtered = quot[SW-1:0];
    r.low = lo_mark;
    r.high = hi_mark;
    r.mean = avg[SW-1:0];
    r.count = run_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d: %s expected %0h, got %0h", checked, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) window_mem[i] = '0;
      wr_pos = 0;
      run_sum = 0;
      run_count = 0;
      lo_mark = '0;
      hi_mark = '0;
      win_len_reg = 1;
      pending_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) win_len_reg = cfg_mon.window_length;
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with no sample pending", checked);
        end else begin
          want = pending_results.pop_front();
          check_field("time_out", want.stamp, out_mon.time_out);
          check_field("filtered_value", 32'(want.filtered), 32'(out_mon.filtered_value));
          check_field("series_min", 32'(want.low), 32'(out_mon.series_min));
          check_field("series_max", 32'(want.high), 32'(out_mon.series_max));
          check_field("series_mean", 32'(want.mean), 32'(out_mon.series_mean));
          check_field("sample_count", want.count, out_mon.sample_count);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(advance_filter(in_mon.series_start, in_mon.sample_time,
                                                 in_mon.sample_value));
    end
    fail_count <= mismatches;
    results_seen <= checked;
  end

endmodule

/* verif/moving_average_min_max_tracker_test.sv */
`timescale 1ns / 1ps
module moving_average_min_max_tracker_test;
  import mamt_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_SAMPLES = 450;
  localparam logic [SW-1:0] VAL_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] VAL_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] VAL_NEG1 = '1;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   items_sent = 0;
  int   series_opened = 0;
  int   cfg_writes = 0;
  bit   quick_phase = 1'b0;
  int   fail_count;
  int   results_seen;

  mamt_in_if  in_ch ();
  mamt_out_if out_ch ();
  mamt_cfg_if cfg_ch ();

  moving_average_min_max_tracker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  moving_average_min_max_tracker_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycles, results_seen,
               items_sent);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_sample(bit st, logic [TIME_W-1:0] stamp, logic [SW-1:0] value);
    int gap;
    gap = quick_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.series_start <= st;
    in_ch.sample_time <= stamp;
    in_ch.sample_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (st) series_opened++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] len);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_length <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = quick_phase ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int               stop_at;
    int               n;
    int               style;
    bit               st;
    logic [SW-1:0]    base;
    logic [SW-1:0]    v;
    logic [CFG_W-1:0] len;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.series_start <= 1'b0;
    in_ch.sample_time <= '0;
    in_ch.sample_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.window_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first sample after reset opens a series without the start flag
    push_sample(1'b0, '0, '0);
    push_sample(1'b0, '1, VAL_MAX);
    push_sample(1'b0, 32'h8000_0000, VAL_MIN);
    push_sample(1'b0, 32'h5555_5555, VAL_NEG1);
    push_sample(1'b0, 32'hAAAA_AAAA, 20'h00001);
    write_window(7'd64);
    push_sample(1'b1, 32'd1, VAL_MAX);
    push_sample(1'b0, 32'd2, VAL_MAX);
    push_sample(1'b0, 32'd3, VAL_MIN);
    push_sample(1'b0, 32'd4, VAL_MIN);
    push_sample(1'b1, 32'd7, 20'hFFFFD);
    push_sample(1'b0, 32'd8, 20'h00002);
    write_window(7'd0);
    push_sample(1'b0, 32'd9, 20'h12345);
    push_sample(1'b0, 32'd10, 20'hEDCBA);
    write_window(7'd127);
    push_sample(1'b0, 32'd11, VAL_MIN);
    write_window(7'd5);
    push_sample(1'b1, 32'd12, 20'h00100);
    for (int i = 0; i < 6; i++) push_sample(1'b0, 32'd13 + i, SW'(20'hFFF00 + i));
    write_window(7'd65);
    push_sample(1'b0, 32'd20, VAL_MAX);
    write_window(7'd3);
    push_sample(1'b0, 32'd21, 20'h00007);
    push_sample(1'b0, 32'd22, 20'hFFFF9);

    stop_at = items_sent + RANDOM_SAMPLES;
    while (items_sent < stop_at) begin
      quick_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: len = 7'd0;
          1: len = 7'd1;
          2: len = 7'd64;
          3: len = CFG_W'($urandom_range(65, 127));
          default: len = CFG_W'($urandom_range(1, 64));
        endcase
        write_window(len);
      end
      n = $urandom_range(1, 40);
      style = $urandom_range(0, 2);
      base = SW'($urandom);
      for (int k = 0; k < n; k++) begin
        st = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
        case (style)
          0: v = SW'($urandom);
          1: begin
            case ($urandom_range(0, 4))
              0: v = VAL_MAX;
              1: v = VAL_MIN;
              2: v = '0;
              3: v = VAL_NEG1;
              default: v = SW'($urandom);
            endcase
          end
          default: v = base + SW'($urandom_range(0, 64)) - SW'(32);
        endcase
        push_sample(st, $urandom, v);
      end
    end

    quick_phase = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples in %0d flagged series starts, %0d window length writes",
             items_sent, series_opened, cfg_writes);
    $display("%0d results checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && results_seen == items_sent) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mamt_pkg.sv
hw/rtl/mamt_if.sv
hw/rtl/moving_average_min_max_tracker.sv
verif/moving_average_min_max_tracker_checker.sv
verif/moving_average_min_max_tracker_test.sv
